>>> design/wavhp_pkg.sv
// Shared types, codes and tag constants for the WAV header parser.
package wavhp_pkg;

	// Kind of result that leaves the block.
	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} result_kind_t;

	// Status codes carried with a result.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_RIFF = 3'd1,
		ST_BAD_WAVE = 3'd2,
		ST_BAD_DATA = 3'd3,
		ST_TRUNC    = 3'd4
	} status_t;

	// Sample format codes of the header result.
	typedef enum logic [2:0] {
		FMT_MONO8    = 3'd0,
		FMT_MONO16   = 3'd1,
		FMT_STEREO8  = 3'd2,
		FMT_STEREO16 = 3'd3,
		FMT_INVALID  = 3'd4
	} format_t;

	// Operation that the front end queues for the back end.
	typedef enum logic [1:0] {
		OP_CAPTURE = 2'd0,
		OP_HEADER  = 2'd1,
		OP_PAYLOAD = 2'd2,
		OP_ERROR   = 2'd3
	} op_kind_t;

	// Header field that a capture operation writes.
	typedef enum logic [1:0] {
		CAP_CHANNELS = 2'd0,
		CAP_RATE     = 2'd1,
		CAP_WIDTH    = 2'd2,
		CAP_SIZE     = 2'd3
	} cap_field_t;

	// One queued operation.
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] byte_val;
		cap_field_t field;
		logic [1:0] lane;
		status_t    status;
		logic       last;
	} wavhp_op_t;

	// Tag characters in ASCII.
	localparam logic [7:0] CHR_R = 8'h52;
	localparam logic [7:0] CHR_I = 8'h49;
	localparam logic [7:0] CHR_F = 8'h46;
	localparam logic [7:0] CHR_W = 8'h57;
	localparam logic [7:0] CHR_A = 8'h41;
	localparam logic [7:0] CHR_V = 8'h56;
	localparam logic [7:0] CHR_E = 8'h45;
	localparam logic [7:0] CHR_D = 8'h64;
	localparam logic [7:0] CHR_T = 8'h74;
	localparam logic [7:0] CHR_LA = 8'h61;

	// Expected byte at a tag position of the header, zero elsewhere.
	function automatic logic [7:0] tag_byte(input logic [5:0] pos);
		logic [7:0] r;
		unique case (pos)
			6'd0:    r = CHR_R;
			6'd1:    r = CHR_I;
			6'd2:    r = CHR_F;
			6'd3:    r = CHR_F;
			6'd8:    r = CHR_W;
			6'd9:    r = CHR_A;
			6'd10:   r = CHR_V;
			6'd11:   r = CHR_E;
			6'd36:   r = CHR_D;
			6'd37:   r = CHR_LA;
			6'd38:   r = CHR_T;
			6'd39:   r = CHR_LA;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

>>> design/wavhp_front.sv
// Front end: tracks the parse position and classifies each byte into an operation.
module wavhp_front import wavhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_value,
	input  logic       start_of_file,
	input  logic       end_of_file,
	input  logic       q_full,
	output logic       q_push,
	output wavhp_op_t  q_item
);

	// Parse phases.
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_IGNORE  = 2'd3
	} phase_t;

	// Header positions of interest.
	localparam logic [5:0] POS_RIFF_END = 6'd3;
	localparam logic [5:0] POS_WAVE_LO  = 6'd8;
	localparam logic [5:0] POS_WAVE_END = 6'd11;
	localparam logic [5:0] POS_CH_LO    = 6'd22;
	localparam logic [5:0] POS_CH_HI    = 6'd23;
	localparam logic [5:0] POS_RATE_LO  = 6'd24;
	localparam logic [5:0] POS_RATE_HI  = 6'd27;
	localparam logic [5:0] POS_BITS_LO  = 6'd34;
	localparam logic [5:0] POS_BITS_HI  = 6'd35;
	localparam logic [5:0] POS_DATA_LO  = 6'd36;
	localparam logic [5:0] POS_DATA_END = 6'd39;
	localparam logic [5:0] POS_SIZE_LO  = 6'd40;
	localparam logic [5:0] POS_LAST     = 6'd43;

	phase_t      phase_q, phase_n, ph;
	logic [5:0]  pos_q, pos_n, pos;
	logic        mm_q, mm_n, mm, mm_hit;
	logic [31:0] size_q, size_n, size_full;
	logic [31:0] rem_q, rem_n, rem_dec;
	logic        is_tag, tag_end, push_c, accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = push_c && accept;

	assign size_full = {byte_value, size_q[23:0]};
	assign rem_dec   = rem_q - 32'd1;

	// Classify the byte against the current phase and header position.
	always_comb begin
		ph      = start_of_file ? PH_HEADER : phase_q;
		pos     = start_of_file ? 6'd0 : pos_q;
		mm      = start_of_file ? 1'b0 : mm_q;
		phase_n = ph;
		pos_n   = pos;
		mm_n    = mm;
		size_n  = size_q;
		rem_n   = rem_q;
		push_c  = 1'b0;
		q_item  = '{kind: OP_CAPTURE, byte_val: byte_value, field: CAP_CHANNELS,
			lane: 2'd0, status: ST_OK, last: 1'b0};
		is_tag  = (pos <= POS_RIFF_END)
			|| (pos >= POS_WAVE_LO && pos <= POS_WAVE_END)
			|| (pos >= POS_DATA_LO && pos <= POS_DATA_END);
		tag_end = (pos == POS_RIFF_END) || (pos == POS_WAVE_END) || (pos == POS_DATA_END);
		mm_hit  = mm || (is_tag && (byte_value != tag_byte(pos)));
		unique case (ph)
			PH_PAYLOAD: begin
				push_c      = 1'b1;
				q_item.kind = OP_PAYLOAD;
				rem_n       = rem_dec;
				if (rem_dec == 32'd0) begin
					q_item.last = 1'b1;
					phase_n     = PH_IGNORE;
				end else if (end_of_file) begin
					q_item.last   = 1'b1;
					q_item.status = ST_TRUNC;
					rem_n         = 32'd0;
					phase_n       = PH_IGNORE;
				end
			end
			PH_HEADER: begin
				mm_n = mm_hit;
				// Field bytes go to the back end for capture.
				if (pos == POS_CH_LO || pos == POS_CH_HI) begin
					push_c       = 1'b1;
					q_item.field = CAP_CHANNELS;
					q_item.lane  = {1'b0, pos[0]};
				end else if (pos >= POS_RATE_LO && pos <= POS_RATE_HI) begin
					push_c       = 1'b1;
					q_item.field = CAP_RATE;
					q_item.lane  = pos[1:0];
				end else if (pos == POS_BITS_LO || pos == POS_BITS_HI) begin
					push_c       = 1'b1;
					q_item.field = CAP_WIDTH;
					q_item.lane  = {1'b0, pos[0]};
				end else if (pos >= POS_SIZE_LO && pos < POS_LAST) begin
					push_c       = 1'b1;
					q_item.field = CAP_SIZE;
					q_item.lane  = pos[1:0];
					size_n[8*pos[1:0] +: 8] = byte_value;
				end
				// Tag failure, header end, truncation, or advance.
				if (tag_end && mm_hit) begin
					push_c      = 1'b1;
					q_item.kind = OP_ERROR;
					if (pos == POS_RIFF_END) begin
						q_item.status = ST_BAD_RIFF;
					end else if (pos == POS_WAVE_END) begin
						q_item.status = ST_BAD_WAVE;
					end else begin
						q_item.status = ST_BAD_DATA;
					end
					phase_n = PH_IGNORE;
				end else if (pos == POS_LAST) begin
					push_c      = 1'b1;
					q_item.kind = OP_HEADER;
					rem_n       = size_full;
					size_n      = size_full;
					if (size_full == 32'd0) begin
						q_item.last = 1'b1;
						phase_n     = PH_IGNORE;
					end else if (end_of_file) begin
						q_item.status = ST_TRUNC;
						rem_n         = 32'd0;
						phase_n       = PH_IGNORE;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end else if (end_of_file) begin
					push_c        = 1'b1;
					q_item.kind   = OP_ERROR;
					q_item.status = ST_TRUNC;
					phase_n       = PH_IGNORE;
				end else begin
					pos_n = pos + 6'd1;
					if (tag_end) begin
						mm_n = 1'b0;
					end
				end
			end
			default: begin
				push_c = 1'b0;
			end
		endcase
	end

	// Parse state, updated on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= 6'd0;
			mm_q    <= 1'b0;
			size_q  <= 32'd0;
			rem_q   <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			mm_q    <= mm_n;
			size_q  <= size_n;
			rem_q   <= rem_n;
		end
	end

endmodule

>>> design/wavhp_fifo.sv
// Short operation queue between the front end and the back end.
module wavhp_fifo import wavhp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  wavhp_op_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      nonempty,
	output wavhp_op_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	wavhp_op_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> design/wavhp_back.sv
// Back end: captures header fields and forms registered results.
module wavhp_back import wavhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  wavhp_op_t   q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [2:0]  status,
	output logic [15:0] channels,
	output logic [31:0] sample_rate,
	output logic [15:0] bits_per_sample,
	output logic [31:0] data_size,
	output logic [2:0]  format_code,
	output logic [7:0]  data_byte,
	output logic        last_of_data
);

	logic [15:0]  ch_q, width_q;
	logic [31:0]  rate_q, size_q, size_full;
	logic         out_valid_q;
	result_kind_t kind_q;
	status_t      status_q;
	format_t      fmt_q, fmt;
	logic [15:0]  ch_o_q, width_o_q;
	logic [31:0]  rate_o_q, size_o_q;
	logic [7:0]   byte_q;
	logic         last_q;

	assign q_pop     = q_nonempty && (!out_valid_q || out_ready);
	assign size_full = {q_head.byte_val, size_q[23:0]};

	// Sample format from the captured channel count and sample width.
	always_comb begin
		if (ch_q == 16'd1 && width_q == 16'd8) begin
			fmt = FMT_MONO8;
		end else if (ch_q == 16'd1 && width_q == 16'd16) begin
			fmt = FMT_MONO16;
		end else if (ch_q == 16'd2 && width_q == 16'd8) begin
			fmt = FMT_STEREO8;
		end else if (ch_q == 16'd2 && width_q == 16'd16) begin
			fmt = FMT_STEREO16;
		end else begin
			fmt = FMT_INVALID;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= (q_head.kind != OP_CAPTURE);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Field captures and result payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			unique case (q_head.kind)
				OP_CAPTURE: begin
					unique case (q_head.field)
						CAP_CHANNELS: ch_q[8*q_head.lane[0] +: 8]    <= q_head.byte_val;
						CAP_RATE:     rate_q[8*q_head.lane +: 8]     <= q_head.byte_val;
						CAP_WIDTH:    width_q[8*q_head.lane[0] +: 8] <= q_head.byte_val;
						CAP_SIZE:     size_q[8*q_head.lane +: 8]     <= q_head.byte_val;
					endcase
				end
				OP_HEADER: begin
					size_q    <= size_full;
					kind_q    <= KIND_HEADER;
					status_q  <= q_head.status;
					ch_o_q    <= ch_q;
					rate_o_q  <= rate_q;
					width_o_q <= width_q;
					size_o_q  <= size_full;
					fmt_q     <= fmt;
					byte_q    <= 8'd0;
					last_q    <= q_head.last;
				end
				OP_PAYLOAD: begin
					kind_q    <= KIND_PAYLOAD;
					status_q  <= q_head.status;
					ch_o_q    <= 16'd0;
					rate_o_q  <= 32'd0;
					width_o_q <= 16'd0;
					size_o_q  <= 32'd0;
					fmt_q     <= FMT_MONO8;
					byte_q    <= q_head.byte_val;
					last_q    <= q_head.last;
				end
				OP_ERROR: begin
					kind_q    <= KIND_ERROR;
					status_q  <= q_head.status;
					ch_o_q    <= 16'd0;
					rate_o_q  <= 32'd0;
					width_o_q <= 16'd0;
					size_o_q  <= 32'd0;
					fmt_q     <= FMT_MONO8;
					byte_q    <= 8'd0;
					last_q    <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign status          = status_q;
	assign channels        = ch_o_q;
	assign sample_rate     = rate_o_q;
	assign bits_per_sample = width_o_q;
	assign data_size       = size_o_q;
	assign format_code     = fmt_q;
	assign data_byte       = byte_q;
	assign last_of_data    = last_q;

endmodule

>>> design/wav_header_parser.sv
// Top level of the WAV header parser: front end, operation queue and back end.
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid / in_ready     byte_value, start_of_file, end_of_file
//   result    out        out_valid / out_ready   result_kind, status, channels, sample_rate,
//                                                bits_per_sample, data_size, format_code,
//                                                data_byte, last_of_data
//
// One byte is accepted per cycle while the queue has room; a result is written to the queue,
// then to the back end's output register, from which it leaves the block.
// The front end takes a byte whenever the operation queue has room; the back end drains one
// operation per cycle while its output register is empty or being taken.
// A stalled output fills the queue, after which in_ready drops until it drains.
// Reset clears the parse state, the queue and the output valid flag; no clearing pass.
module wav_header_parser import wavhp_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        start_of_file,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [2:0]  status,
	output logic [15:0] channels,
	output logic [31:0] sample_rate,
	output logic [15:0] bits_per_sample,
	output logic [31:0] data_size,
	output logic [2:0]  format_code,
	output logic [7:0]  data_byte,
	output logic        last_of_data
);

	logic      q_push, q_full, q_pop, q_nonempty;
	wavhp_op_t q_item, q_head;

	// Byte classification and parse state.
	wavhp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_value    (byte_value),
		.start_of_file (start_of_file),
		.end_of_file   (end_of_file),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	// Operation queue.
	wavhp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	// Field capture and result output.
	wavhp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_nonempty      (q_nonempty),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.status          (status),
		.channels        (channels),
		.sample_rate     (sample_rate),
		.bits_per_sample (bits_per_sample),
		.data_size       (data_size),
		.format_code     (format_code),
		.data_byte       (data_byte),
		.last_of_data    (last_of_data)
	);

	// An error report always carries a failure status and never a last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_ERROR |-> status != ST_OK && !last_of_data)
		else $error("error result without failure status");

	// A header marked last declares an empty payload and is not truncated.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_HEADER && last_of_data
		|-> data_size == 32'd0 && status == ST_OK)
		else $error("header marked last with nonzero size");

	// A truncated payload byte closes the data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PAYLOAD && status == ST_TRUNC |-> last_of_data)
		else $error("truncated payload byte not marked last");

endmodule
